// ===== rtl/tspl_pkg.sv =====
// ----------------------------------------------------------------------------
// tspl_pkg
// Shared constants, register indexes and constant table builders for the
// three-segment path loss gain block.
// ----------------------------------------------------------------------------
`default_nettype none

package tspl_pkg;

  localparam int SAMPLE_BITS_DEFAULT    = 16;
  localparam int LOG_TABLE_BITS_DEFAULT = 8;

  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int EXP_BITS       = 12;
  localparam int DIST_BITS      = 24;
  localparam int LOSS_BITS      = 16;
  localparam int GAIN_DB_BITS   = 17;

  localparam logic [EXP_BITS-1:0]  NEAR_EXPONENT_RST     = 12'd486;
  localparam logic [EXP_BITS-1:0]  MIDDLE_EXPONENT_RST   = 12'd973;
  localparam logic [EXP_BITS-1:0]  FAR_EXPONENT_RST      = 12'd973;
  localparam logic [DIST_BITS-1:0] FIRST_BREAKPOINT_RST  = 24'd256;
  localparam logic [DIST_BITS-1:0] SECOND_BREAKPOINT_RST = 24'd51200;
  localparam logic [DIST_BITS-1:0] THIRD_BREAKPOINT_RST  = 24'd128000;
  localparam logic [LOSS_BITS-1:0] REFERENCE_LOSS_RST    = 16'd11949;

  // 10*log10(2) in Q.16 and log2(10)/20 in Q.20
  localparam logic [17:0] TEN_LOG10_TWO_Q16  = 18'd197283;
  localparam logic [17:0] LOG2_TEN_DIV20_Q20 = 18'd174165;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NEAR_EXPONENT     = 3'd0,
    REG_MIDDLE_EXPONENT   = 3'd1,
    REG_FAR_EXPONENT      = 3'd2,
    REG_FIRST_BREAKPOINT  = 3'd3,
    REG_SECOND_BREAKPOINT = 3'd4,
    REG_THIRD_BREAKPOINT  = 3'd5,
    REG_REFERENCE_LOSS    = 3'd6
  } reg_index_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bv;
    int k;
    v   = v_in;
    res = 64'd0;
    bv  = 64'd1 << 62;
    for (k = 0; k < 32; k++) begin
      if (bv > v) bv = bv >> 2;
    end
    for (k = 0; k < 32; k++) begin
      if (bv != 64'd0) begin
        if (v >= res + bv) begin
          v   = v - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/2^t) in Q.16 by repeated squaring
  function automatic logic [16:0] log_entry(input int t, input int i);
    logic [63:0] y;
    logic [31:0] r;
    logic [31:0] ab;
    int k;
    y  = 64'((1 << t) + i) << (30 - t);
    r  = 32'd0;
    ab = 32'd1 << 15;
    for (k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        r = r | ab;
        y = y >> 1;
      end
      ab = ab >> 1;
    end
    if (i == (1 << t)) r = 32'd65536;
    return r[16:0];
  endfunction

  // 2^(-i/2^t) in Q.30 as a product of square roots
  function automatic logic [30:0] exp_entry(input int t, input int i);
    logic [63:0] roots [0:12];
    logic [63:0] acc;
    int k;
    for (k = 0; k <= 12; k++) roots[k] = 64'd0;
    roots[0] = 64'd1 << 29;
    roots[1] = isqrt64(64'd1 << 59);
    for (k = 2; k <= t; k++) roots[k] = isqrt64(roots[k-1] << 30);
    acc = 64'd1 << 30;
    for (k = 0; k < t; k++) begin
      if (((i >> k) & 1) != 0) acc = (acc * roots[t-k] + (64'd1 << 29)) >> 30;
    end
    if (i == (1 << t)) acc = roots[0];
    return acc[30:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/three_segment_path_loss_gain.sv =====
// ----------------------------------------------------------------------------
// three_segment_path_loss_gain
// Three-segment log-distance path loss and complex sample attenuation.
// ----------------------------------------------------------------------------
// A thirteen-stage pipeline: one item enters per clock, the pipeline stalling
// as a whole only while the output register holds an item not yet taken. The
// stages in order are normalize, log2 lookup, interpolation, log difference,
// two multiplies per segment term, loss sum and clamp, loss to exponent
// multiply, exp lookup, exp interpolation, sample multiply, shift and
// saturation, one register stage each.
`default_nettype none

module three_segment_path_loss_gain #(
  parameter int SAMPLE_BITS    = tspl_pkg::SAMPLE_BITS_DEFAULT,
  parameter int LOG_TABLE_BITS = tspl_pkg::LOG_TABLE_BITS_DEFAULT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write,
  input  wire logic [tspl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [tspl_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                                    item_valid,
  output logic                                         item_ready,
  input  wire logic [tspl_pkg::DIST_BITS-1:0]          link_distance,
  input  wire logic signed [SAMPLE_BITS-1:0]           sample_in_real,
  input  wire logic signed [SAMPLE_BITS-1:0]           sample_in_imag,
  output logic                                         result_valid,
  input  wire logic                                    result_ready,
  output logic signed [SAMPLE_BITS-1:0]                sample_out_real,
  output logic signed [SAMPLE_BITS-1:0]                sample_out_imag,
  output logic signed [tspl_pkg::GAIN_DB_BITS-1:0]     gain_db
);

  localparam int T    = LOG_TABLE_BITS;
  localparam int TAB  = (1 << T) + 1;
  localparam int LSH  = 23 - T;
  localparam int ESH  = 16 - T;
  localparam int NST  = 13;
  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = SB + 32;
  localparam logic [39:0] LRND = 40'd1 << (LSH - 1);
  localparam logic [47:0] ERND = 48'd1 << (ESH - 1);
  localparam logic [SB:0] POS_MAX = (SB+1)'((1 << (SB - 1)) - 1);
  localparam logic [SB:0] NEG_MAX = (SB+1)'(1 << (SB - 1));

  // constant tables
  logic [16:0] log_rom [0:TAB-1];
  logic [30:0] exp_rom [0:TAB-1];
  for (genvar gi = 0; gi < TAB; gi++) begin : g_rom
    assign log_rom[gi] = tspl_pkg::log_entry(T, gi);
    assign exp_rom[gi] = tspl_pkg::exp_entry(T, gi);
  end

  // configuration registers
  logic [tspl_pkg::EXP_BITS-1:0]  near_exponent, middle_exponent, far_exponent;
  logic [tspl_pkg::DIST_BITS-1:0] first_breakpoint, second_breakpoint, third_breakpoint;
  logic [tspl_pkg::LOSS_BITS-1:0] reference_loss;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_exponent     <= tspl_pkg::NEAR_EXPONENT_RST;
      middle_exponent   <= tspl_pkg::MIDDLE_EXPONENT_RST;
      far_exponent      <= tspl_pkg::FAR_EXPONENT_RST;
      first_breakpoint  <= tspl_pkg::FIRST_BREAKPOINT_RST;
      second_breakpoint <= tspl_pkg::SECOND_BREAKPOINT_RST;
      third_breakpoint  <= tspl_pkg::THIRD_BREAKPOINT_RST;
      reference_loss    <= tspl_pkg::REFERENCE_LOSS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tspl_pkg::REG_NEAR_EXPONENT:     near_exponent     <= cfg_data[11:0];
        tspl_pkg::REG_MIDDLE_EXPONENT:   middle_exponent   <= cfg_data[11:0];
        tspl_pkg::REG_FAR_EXPONENT:      far_exponent      <= cfg_data[11:0];
        tspl_pkg::REG_FIRST_BREAKPOINT:  first_breakpoint  <= cfg_data;
        tspl_pkg::REG_SECOND_BREAKPOINT: second_breakpoint <= cfg_data;
        tspl_pkg::REG_THIRD_BREAKPOINT:  third_breakpoint  <= cfg_data;
        tspl_pkg::REG_REFERENCE_LOSS:    reference_loss    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NST:1] v;
  logic         en;
  assign en         = !v[NST] || result_ready;
  assign item_ready = en;
  assign result_valid = v[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-1:1], item_valid};
    end
  end

  // sample and segment shift lines
  logic signed [SB-1:0] re_q [1:NST];
  logic signed [SB-1:0] im_q [1:NST];
  logic [1:0]           seg_q [1:6];

  // stage 1: normalize
  logic [23:0] bp   [0:2];
  logic [23:0] xs   [0:3];
  logic [4:0]  e_c  [0:3];
  logic [22:0] m_c  [0:3];
  logic [1:0]  seg_c;
  logic [4:0]  e1   [0:3];
  logic [T-1:0]   idx1 [0:3];
  logic [LSH-1:0] rem1 [0:3];

  always_comb begin
    bp[0] = (first_breakpoint  == '0) ? 24'd1 : first_breakpoint;
    bp[1] = (second_breakpoint == '0) ? 24'd1 : second_breakpoint;
    bp[2] = (third_breakpoint  == '0) ? 24'd1 : third_breakpoint;
    xs[0] = link_distance;
    xs[1] = bp[0];
    xs[2] = bp[1];
    xs[3] = bp[2];
    for (int j = 0; j < 4; j++) begin
      e_c[j] = 5'd0;
      for (int b = 0; b < 24; b++) begin
        if (xs[j][b]) e_c[j] = 5'(b);
      end
      m_c[j] = 23'(xs[j] << (5'd23 - e_c[j]));
    end
    priority if (link_distance < bp[0]) seg_c = 2'd0;
    else if (link_distance < bp[1])     seg_c = 2'd1;
    else if (link_distance < bp[2])     seg_c = 2'd2;
    else                                seg_c = 2'd3;
  end

  // stage 2: table lookup
  logic [16:0] df_2 [0:3];
  logic [4:0]  e2   [0:3];
  logic [LSH-1:0] rem2 [0:3];

  // stage 3: interpolation
  logic [20:0] lg3 [0:3];
  logic [39:0] ip_c [0:3];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ip_c[j] = 40'(df_2[j]) * 40'(rem2[j]) + LRND;
    end
  end

  // stage 4: log deltas per segment
  logic [20:0] hi_c [0:2];
  logic [20:0] lo_c [0:2];
  logic [21:0] dl_c [0:2];
  logic [20:0] mag4 [0:2];
  logic [2:0]  neg4;

  always_comb begin
    hi_c[0] = (seg_q[3] == 2'd1) ? lg3[0] : lg3[2];
    lo_c[0] = lg3[1];
    hi_c[1] = (seg_q[3] == 2'd2) ? lg3[0] : lg3[3];
    lo_c[1] = lg3[2];
    hi_c[2] = lg3[0];
    lo_c[2] = lg3[3];
    for (int j = 0; j < 3; j++) begin
      dl_c[j] = {1'b0, hi_c[j]} - {1'b0, lo_c[j]};
    end
  end

  // stage 5: times exponent
  logic [32:0] pm5 [0:2];
  logic [2:0]  neg5;
  logic [11:0] ex_c [0:2];
  assign ex_c[0] = near_exponent;
  assign ex_c[1] = middle_exponent;
  assign ex_c[2] = far_exponent;

  // stage 6: times 10*log10(2), rounded
  logic [51:0] big_c [0:2];
  logic [18:0] r6    [0:2];
  logic [2:0]  neg6;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      big_c[j] = 52'(pm5[j]) * 52'(tspl_pkg::TEN_LOG10_TWO_Q16) + (52'd1 << 31);
    end
  end

  // stage 7: total loss with clamp
  logic signed [22:0] tm_c [0:2];
  logic signed [22:0] sum_c;
  logic [15:0]        loss_c;
  logic [15:0]        loss_q [7:NST-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tm_c[j] = neg6[j] ? -23'(r6[j]) : 23'(r6[j]);
    end
    sum_c = 23'(reference_loss);
    unique case (seg_q[6])
      2'd0: sum_c = '0;
      2'd1: sum_c = sum_c + tm_c[0];
      2'd2: sum_c = sum_c + tm_c[0] + tm_c[1];
      2'd3: sum_c = sum_c + tm_c[0] + tm_c[1] + tm_c[2];
      default: sum_c = '0;
    endcase
    priority if (sum_c < 0)      loss_c = 16'd0;
    else if (sum_c > 23'sd65535) loss_c = 16'hFFFF;
    else                         loss_c = sum_c[15:0];
  end

  // stage 8: exponent of two
  logic [34:0]    pp_c;
  logic [5:0]     n_q [8:11];
  logic [T-1:0]   eidx8;
  logic [ESH-1:0] erem8;
  assign pp_c = 35'(loss_q[7]) * 35'(tspl_pkg::LOG2_TEN_DIV20_Q20) + 35'd2048;

  // stage 9: exp lookup
  logic [30:0]    e0_9;
  logic [29:0]    ed_9;
  logic [ESH-1:0] erem9;

  // stage 10: gain
  logic [47:0] gi_c;
  logic [30:0] g10;
  assign gi_c = 48'(ed_9) * 48'(erem9) + ERND;

  // stage 11: sample times gain
  logic [SB:0]   mre_c, mim_c;
  logic [PW-1:0] pre11, pim11;
  always_comb begin
    mre_c = re_q[10][SB-1] ? -(SB+1)'(re_q[10]) : (SB+1)'(re_q[10]);
    mim_c = im_q[10][SB-1] ? -(SB+1)'(im_q[10]) : (SB+1)'(im_q[10]);
  end

  // stage 12: rounding shift
  logic [6:0]  sh_c;
  logic [63:0] rnd_c, sre_c, sim_c;
  logic [SB:0] qre12, qim12;
  always_comb begin
    sh_c  = 7'd30 + 7'(n_q[11]);
    rnd_c = 64'd1 << (sh_c - 7'd1);
    sre_c = (64'(pre11) + rnd_c) >> sh_c;
    sim_c = (64'(pim11) + rnd_c) >> sh_c;
    if (sh_c >= 7'd63) begin
      sre_c = '0;
      sim_c = '0;
    end
  end

  // stage 13: sign and saturate
  logic signed [SB-1:0] ore_c, oim_c;
  always_comb begin
    if (re_q[12][SB-1]) ore_c = (qre12 > NEG_MAX) ? SB'(NEG_MAX) : -SB'(qre12);
    else                ore_c = (qre12 > POS_MAX) ? SB'(POS_MAX) : SB'(qre12);
    if (im_q[12][SB-1]) oim_c = (qim12 > NEG_MAX) ? SB'(NEG_MAX) : -SB'(qim12);
    else                oim_c = (qim12 > POS_MAX) ? SB'(POS_MAX) : SB'(qim12);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_q[1]  <= sample_in_real;
      im_q[1]  <= sample_in_imag;
      for (int k = 2; k <= NST; k++) begin
        re_q[k] <= re_q[k-1];
        im_q[k] <= im_q[k-1];
      end
      seg_q[1] <= seg_c;
      for (int k = 2; k <= 6; k++) seg_q[k] <= seg_q[k-1];
      for (int j = 0; j < 4; j++) begin
        e1[j]   <= e_c[j];
        idx1[j] <= m_c[j][22:LSH];
        rem1[j] <= m_c[j][LSH-1:0];
        e2[j]   <= e1[j];
        rem2[j] <= rem1[j];
        df_2[j] <= log_rom[(T+1)'(idx1[j]) + (T+1)'(1)] - log_rom[idx1[j]];
        lg3[j]  <= {e2[j], 16'd0} + 21'(ip_c[j] >> LSH);
      end
      for (int j = 0; j < 3; j++) begin
        neg4[j] <= dl_c[j][21];
        mag4[j] <= dl_c[j][21] ? 21'(-dl_c[j]) : dl_c[j][20:0];
        pm5[j]  <= 33'(mag4[j]) * 33'(ex_c[j]);
        r6[j]   <= big_c[j][50:32];
      end
      neg5 <= neg4;
      neg6 <= neg5;
      loss_q[7] <= loss_c;
      for (int k = 8; k <= NST-1; k++) loss_q[k] <= loss_q[k-1];
      n_q[8] <= pp_c[33:28];
      eidx8  <= pp_c[27:12+ESH];
      erem8  <= pp_c[12+ESH-1:12];
      for (int k = 9; k <= 11; k++) n_q[k] <= n_q[k-1];
      e0_9  <= exp_rom[eidx8];
      ed_9  <= 30'(exp_rom[eidx8] - exp_rom[(T+1)'(eidx8) + (T+1)'(1)]);
      erem9 <= erem8;
      g10   <= e0_9 - 31'(gi_c >> ESH);
      pre11 <= PW'(mre_c) * PW'(g10);
      pim11 <= PW'(mim_c) * PW'(g10);
      qre12 <= sre_c[SB:0];
      qim12 <= sim_c[SB:0];
      sample_out_real <= ore_c;
      sample_out_imag <= oim_c;
      gain_db <= -$signed({1'b0, loss_q[12]});
    end
  end

  // checks
  a_gain_nonpositive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (gain_db[16] || gain_db == '0))
    else $error("gain_db positive");

  a_zero_loss_passes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && gain_db == '0) |->
      (sample_out_real == re_q[NST] && sample_out_imag == im_q[NST]))
    else $error("zero loss changed sample");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> (v == $past(v)))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the three-segment path loss gain block. Directed and random
// complex samples at a range of link distances go in under several register
// settings. Each result is checked field by field against an in-bench
// fixed-point predictor of the loss, the gain and the scaled sample. Both
// handshakes idle at random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int SB = tspl_pkg::SAMPLE_BITS_DEFAULT;
  localparam int TB = tspl_pkg::LOG_TABLE_BITS_DEFAULT;
  localparam int TN = 1 << TB;
  localparam logic [tspl_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [tspl_pkg::DIST_BITS-1:0] distance;
    logic signed [SB-1:0] re;
    logic signed [SB-1:0] im;
  } link_item_t;

  typedef struct {
    logic signed [SB-1:0] re;
    logic signed [SB-1:0] im;
    logic signed [tspl_pkg::GAIN_DB_BITS-1:0] db;
  } scaled_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [tspl_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [tspl_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [tspl_pkg::DIST_BITS-1:0] link_distance = '0;
  logic signed [SB-1:0] sample_in_real = '0;
  logic signed [SB-1:0] sample_in_imag = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [SB-1:0] sample_out_real;
  logic signed [SB-1:0] sample_out_imag;
  logic signed [tspl_pkg::GAIN_DB_BITS-1:0] gain_db;

  three_segment_path_loss_gain dut (.*);

  always #5 clk = ~clk;

  // shadow registers
  logic [11:0] near_exp, mid_exp, far_exp;
  logic [23:0] bp1, bp2, bp3;
  logic [15:0] ref_loss;

  logic [31:0] log2_rom [0:TN];
  logic [63:0] pow2_rom [0:TN];

  link_item_t pending_items[$];
  scaled_t    scaled_due[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit no_idle = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v, res, bv;
    v = v_in;
    res = 0;
    bv = 64'd1 << 62;
    while (bv > v) bv = bv >> 2;
    while (bv != 0) begin
      if (v >= res + bv) begin
        v = v - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  task automatic fill_roms();
    logic [63:0] roots [0:TB];
    logic [63:0] y, acc;
    logic [31:0] r, ab;
    roots[0] = 64'd1 << 29;
    roots[1] = int_sqrt(64'd1 << 59);
    for (int k = 2; k <= TB; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    for (int i = 0; i < TN; i++) begin
      y = 64'(TN + i) << (30 - TB);
      r = 0;
      ab = 32'd1 << 15;
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          r = r | ab;
          y = y >> 1;
        end
        ab = ab >> 1;
      end
      log2_rom[i] = r;
      acc = 64'd1 << 30;
      for (int k = 0; k < TB; k++)
        if ((i >> k) & 1) acc = (acc * roots[TB-k] + (64'd1 << 29)) >> 30;
      pow2_rom[i] = acc;
    end
    log2_rom[TN] = 32'd65536;
    pow2_rom[TN] = roots[0];
  endtask

  function automatic logic [31:0] log2_fix(input logic [23:0] x);
    int e;
    logic [31:0] m, idx, rem, t0, t1;
    logic [63:0] p;
    e = 23;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (32'(x) << (23 - e)) & 32'h7FFFFF;
    idx = m >> (23 - TB);
    rem = m & ((32'd1 << (23 - TB)) - 1);
    t0 = log2_rom[idx];
    t1 = log2_rom[idx + 1];
    p = (64'(t1 - t0) * rem + (64'd1 << (22 - TB))) >> (23 - TB);
    return (32'(e) << 16) + p[31:0];
  endfunction

  function automatic longint segment_db(input logic [11:0] ex, input logic [23:0] hi,
                                        input logic [23:0] lo);
    longint delta, r;
    logic [63:0] mag;
    delta = longint'(log2_fix(hi)) - longint'(log2_fix(lo));
    mag = 64'(delta < 0 ? -delta : delta) * ex * 64'd197283;
    r = longint'((mag + (64'd1 << 31)) >> 32);
    return delta < 0 ? -r : r;
  endfunction

  function automatic logic signed [SB-1:0] attenuate(input logic signed [SB-1:0] s,
                                                     input logic [63:0] g, input int sh);
    logic [63:0] mag, q;
    longint v;
    mag = s < 0 ? 64'(-longint'(s)) : 64'(s);
    q = (sh >= 63) ? 0 : ((mag * g + (64'd1 << (sh - 1))) >> sh);
    v = s < 0 ? -longint'(q) : longint'(q);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SB-1:0];
  endfunction

  function automatic scaled_t predict_scaled(input link_item_t it);
    scaled_t o;
    logic [23:0] b0, b1, b2;
    longint loss;
    logic [63:0] p, fr, rem, e0, e1, g;
    int n;
    b0 = bp1 == 0 ? 24'd1 : bp1;
    b1 = bp2 == 0 ? 24'd1 : bp2;
    b2 = bp3 == 0 ? 24'd1 : bp3;
    if (it.distance < b0) begin
      loss = 0;
    end else begin
      loss = ref_loss;
      if (it.distance < b1) loss += segment_db(near_exp, it.distance, b0);
      else if (it.distance < b2)
        loss += segment_db(near_exp, b1, b0) + segment_db(mid_exp, it.distance, b1);
      else
        loss += segment_db(near_exp, b1, b0) + segment_db(mid_exp, b2, b1)
              + segment_db(far_exp, it.distance, b2);
      if (loss < 0) loss = 0;
      if (loss > 65535) loss = 65535;
    end
    p = (64'(loss) * 64'd174165 + (64'd1 << 11)) >> 12;
    n = int'(p >> 16);
    fr = p & 64'hFFFF;
    rem = fr & ((64'd1 << (16 - TB)) - 1);
    e0 = pow2_rom[fr >> (16 - TB)];
    e1 = pow2_rom[(fr >> (16 - TB)) + 1];
    g = e0 - (((e0 - e1) * rem + (64'd1 << (15 - TB))) >> (16 - TB));
    o.re = attenuate(it.re, g, 30 + n);
    o.im = attenuate(it.im, g, 30 + n);
    o.db = tspl_pkg::GAIN_DB_BITS'(-loss);
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
  endtask

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    link_item_t it;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        it.distance = link_distance;
        it.re = sample_in_real;
        it.im = sample_in_imag;
        scaled_due.push_back(predict_scaled(it));
        items_sent++;
      end
      if (item_valid && !item_ready) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        link_distance <= it.distance;
        sample_in_real <= it.re;
        sample_in_imag <= it.im;
        item_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver
  int hold_left = 0;
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      result_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  // checker
  always @(posedge clk) begin
    scaled_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (scaled_due.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = scaled_due.pop_front();
        if (sample_out_real !== want.re)
          report_mismatch("sample_out_real", sample_out_real, want.re);
        if (sample_out_imag !== want.im)
          report_mismatch("sample_out_imag", sample_out_imag, want.im);
        if (gain_db !== want.db) report_mismatch("gain_db", gain_db, want.db);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || cfg_write || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [tspl_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [23:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tspl_pkg::REG_NEAR_EXPONENT: near_exp = val[11:0];
      tspl_pkg::REG_MIDDLE_EXPONENT: mid_exp = val[11:0];
      tspl_pkg::REG_FAR_EXPONENT: far_exp = val[11:0];
      tspl_pkg::REG_FIRST_BREAKPOINT: bp1 = val;
      tspl_pkg::REG_SECOND_BREAKPOINT: bp2 = val;
      tspl_pkg::REG_THIRD_BREAKPOINT: bp3 = val;
      tspl_pkg::REG_REFERENCE_LOSS: ref_loss = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(input logic [23:0] ne, input logic [23:0] me, input logic [23:0] fe,
                         input logic [23:0] a, input logic [23:0] b, input logic [23:0] c,
                         input logic [23:0] rl);
    write_reg(tspl_pkg::REG_NEAR_EXPONENT, ne);
    write_reg(tspl_pkg::REG_MIDDLE_EXPONENT, me);
    write_reg(tspl_pkg::REG_FAR_EXPONENT, fe);
    write_reg(tspl_pkg::REG_FIRST_BREAKPOINT, a);
    write_reg(tspl_pkg::REG_SECOND_BREAKPOINT, b);
    write_reg(tspl_pkg::REG_THIRD_BREAKPOINT, c);
    write_reg(tspl_pkg::REG_REFERENCE_LOSS, rl);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || scaled_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_item(input logic [23:0] d, input logic [15:0] re, input logic [15:0] im);
    link_item_t it;
    it.distance = d;
    it.re = re;
    it.im = im;
    pending_items.push_back(it);
  endtask

  function automatic logic [23:0] random_distance();
    int r;
    logic [23:0] b;
    r = $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0: b = bp1;
      1: b = bp2;
      default: b = bp3;
    endcase
    if (r < 3) return b + 24'($urandom_range(0, 8)) - 24'd4;
    if (r < 5) return 24'($urandom);
    return 24'($urandom) & 24'((32'd1 << $urandom_range(1, 24)) - 1);
  endfunction

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 7)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count);
    repeat (count) queue_item(random_distance(), random_sample(), random_sample());
  endtask

  initial begin
    near_exp = tspl_pkg::NEAR_EXPONENT_RST;
    mid_exp = tspl_pkg::MIDDLE_EXPONENT_RST;
    far_exp = tspl_pkg::FAR_EXPONENT_RST;
    bp1 = tspl_pkg::FIRST_BREAKPOINT_RST;
    bp2 = tspl_pkg::SECOND_BREAKPOINT_RST;
    bp3 = tspl_pkg::THIRD_BREAKPOINT_RST;
    ref_loss = tspl_pkg::REFERENCE_LOSS_RST;
    fill_roms();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings
    queue_item(24'd0, 16'h7FFF, 16'h8000);
    queue_item(24'd255, 16'h8000, 16'h7FFF);
    queue_item(24'd256, 16'h7FFF, 16'h8000);
    queue_item(24'd51199, 16'h0001, 16'hFFFF);
    queue_item(24'd51200, 16'h7FFF, 16'h8000);
    queue_item(24'd127999, 16'h4000, 16'hC000);
    queue_item(24'd128000, 16'h7FFF, 16'h8000);
    queue_item(24'hFFFFFF, 16'h7FFF, 16'h8000);
    queue_item(24'hAAAAAA, 16'h5555, 16'hAAAA);
    queue_item(24'h555555, 16'hAAAA, 16'h5555);
    queue_item(24'd1000, 16'h0000, 16'h0000);
    wait_idle();

    // extremes: zero breakpoints, max exponents, max loss (gain underflow)
    set_all(24'hFFFFFF, 24'd4095, 24'd4095, 24'd0, 24'd0, 24'd0, 24'hFFFF);
    write_reg(REG_UNUSED, 24'd0);
    queue_item(24'd0, 16'h7FFF, 16'h8000);
    queue_item(24'd1, 16'h7FFF, 16'h8000);
    queue_item(24'hFFFFFF, 16'h7FFF, 16'h8000);
    queue_random(80);
    wait_idle();

    // zero loss and exponents, then breakpoints out of order
    set_all(24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1, 24'd0);
    queue_item(24'd5, 16'h7FFF, 16'h8000);
    queue_random(40);
    wait_idle();
    set_all(24'd4095, 24'd2000, 24'd300, 24'd900000, 24'd300, 24'd5000, 24'd100);
    queue_item(24'd900000, 16'h7FFF, 16'h8000);
    queue_item(24'hFFFFFF, 16'h7FFF, 16'h8000);
    queue_random(80);
    wait_idle();

    // max breakpoints
    set_all(24'd973, 24'd973, 24'd973, 24'hFFFFFD, 24'hFFFFFE, 24'hFFFFFF, 24'd11949);
    queue_item(24'hFFFFFC, 16'h7FFF, 16'h8000);
    queue_item(24'hFFFFFD, 16'h7FFF, 16'h8000);
    queue_item(24'hFFFFFF, 16'h7FFF, 16'h8000);
    queue_random(40);
    wait_idle();

    // random settings; one phase with a long output stall under full input load
    for (int ph = 0; ph < 4; ph++) begin
      set_all(24'($urandom), 24'($urandom_range(0, 4095)), 24'($urandom_range(0, 4095)),
              24'($urandom_range(1, 4000)), 24'($urandom_range(1000, 200000)),
              24'($urandom_range(100000, 16777215)), 24'($urandom_range(0, 20000)));
      no_idle = (ph == 1);
      queue_random(50);
      if (ph == 2) begin
        no_idle = 1;
        hold_requests++;
      end
      queue_random(50);
      wait_idle();
      no_idle = 0;
    end

    write_reg(tspl_pkg::REG_REFERENCE_LOSS, 24'd0);
    queue_random(40);
    wait_idle();

    $display("Sent %0d items and checked %0d results over 10 register settings,",
             items_sent, results_seen);
    $display("including zero, reversed and full-scale breakpoints and gain underflow.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== three_segment_path_loss_gain.f =====
rtl/tspl_pkg.sv
rtl/three_segment_path_loss_gain.sv
verif/tb_top.sv
